// ----- sv/multichannel_olympic_average_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel olympic averager
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_OLYMPIC_AVERAGE_TOP_ASSERT_SVH
`define MULTICHANNEL_OLYMPIC_AVERAGE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MOA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define MOA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define MOA_ASSERT_IMPLY(lbl, ante, cons)
`define MOA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- sv/moa_pkg.sv -----
// ----------------------------------------------------------------------------
// moa_pkg
// Shared constants and types for the multichannel olympic averager.
// ----------------------------------------------------------------------------
package moa_pkg;

    localparam int CHANNELS  = 4;
    localparam int AVG_SHIFT = 3;
    localparam int RING_LEN  = (1 << AVG_SHIFT) + 2;

    localparam int ADC_W     = 12;
    localparam int ADC_MAX   = (1 << ADC_W) - 1;
    localparam int MV_FULL   = 3300;
    localparam int MV_W      = 12;
    localparam int CH_OUT_W  = 2;

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = $clog2(RING_LEN);
    localparam int IDX_W     = $clog2(RING_LEN + 1);
    localparam int DEPTH     = CHANNELS * RING_LEN;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int SUM_W     = $clog2(RING_LEN * ADC_MAX + 1);
    localparam int PROD_W    = 2 * ADC_W;
    localparam int QUO_W     = PROD_W - ADC_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_TRIM,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic write;
        logic scan;
        logic trim;
        logic mul;
        logic div;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

// ----- sv/multichannel_olympic_average_top.sv -----
// ----------------------------------------------------------------------------
// multichannel_olympic_average_top
// Round-robin trimmed-mean averager with millivolt scaling.
// ----------------------------------------------------------------------------
//
//  Port group   Dir  Handshake             Payload
//  in           in   in_valid/in_ready     raw_sample[11:0]
//  out          out  out_valid/out_ready   channel[1:0], average[11:0], millivolts[11:0]
//
// A word passes from acceptance to the output register through the write,
// ring scan, trim, multiply, divide and emit steps; the scan is a serial walk
// over the channel's ring (ten entries by default) through the single read
// port of the sample memory. The block works on one word at a time; the next
// word is accepted as soon as the previous result has moved into the output
// register, even if that result has not yet been taken. A stalled output
// holds the sequencer in its last step. Reset is asynchronous; all ring
// entries read as zero after reset through per-entry valid bits, so no
// clearing pass is needed.
//
// Each word carries the next sample of the current channel. The channel's
// ring position advances (wrapping after the last slot), the sample is
// stored there, and the whole ring is then summed with its minimum and
// maximum tracked. The trimmed sum is shifted right by AVG_SHIFT, scaled by
// 3300 and divided by 4095 using a shift-and-correct reciprocal.
//
module multichannel_olympic_average_top
    import moa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [ADC_W-1:0]    raw_sample,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CH_OUT_W-1:0] channel,
    output logic [ADC_W-1:0]    average,
    output logic [MV_W-1:0]     millivolts
);

`include "multichannel_olympic_average_top_assert.svh"

    cmd_t    cmd;
    status_t status;
    state_t  state;

    // Sequencer: issues one command per step of the word's processing.
    moa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    // Datapath: sample memory, accumulators, scaling and output register.
    moa_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_sample (raw_sample),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .channel    (channel),
        .average    (average),
        .millivolts (millivolts)
    );

    // A word is never accepted while the previous one is still in process.
    `MOA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // The ready signal is only raised while the sequencer is idle.
    `MOA_ASSERT_IMPLY(a_ready_idle, in_ready, state == ST_IDLE && !cmd.scan)

    // Every emitted result shows up on the output in the next cycle.
    `MOA_ASSERT_NEXT(a_emit_visible, cmd.emit, out_valid)

    // The scaled value never exceeds full scale.
    `MOA_ASSERT_IMPLY(a_mv_range, out_valid, millivolts <= MV_W'(MV_FULL))

endmodule

// ----- sv/moa_ctrl.sv -----
// ----------------------------------------------------------------------------
// moa_ctrl
// Sequencer that steps one word through write, ring scan, trim and scaling.
// ----------------------------------------------------------------------------
module moa_ctrl
    import moa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd,
    output state_t  state
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                cmd.trim   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Wait here until the output register can take the word.
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ----- sv/moa_datapath.sv -----
// ----------------------------------------------------------------------------
// moa_datapath
// Sample rings, scan accumulators, trimmed mean and millivolt scaling.
// ----------------------------------------------------------------------------
module moa_datapath
    import moa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ADC_W-1:0]    raw_sample,
    input  cmd_t                cmd,
    output status_t             status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CH_OUT_W-1:0] channel,
    output logic [ADC_W-1:0]    average,
    output logic [MV_W-1:0]     millivolts
);

    // Sample memory; entries never written since reset read as zero.
    logic [ADC_W-1:0]  ring_mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [ADC_W-1:0]  rdata_reg;
    logic              rvalid_reg;

    logic [CH_W-1:0]   cur_ch_reg;
    logic [POS_W-1:0]  pos_reg [CHANNELS];

    logic [ADC_W-1:0]  sample_reg;
    logic [CH_W-1:0]   item_ch_reg;
    logic [POS_W-1:0]  item_pos_reg;
    logic [ADDR_W-1:0] base_reg;

    logic [IDX_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [ADC_W-1:0]  lo_reg;
    logic [ADC_W-1:0]  hi_reg;
    logic [ADC_W-1:0]  avg_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic                out_valid_reg;
    logic [CH_OUT_W-1:0] channel_reg;
    logic [ADC_W-1:0]    average_reg;
    logic [MV_W-1:0]     mv_reg;

    logic [POS_W-1:0]  pos_cur;
    logic [POS_W-1:0]  pos_new;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              rd_en;
    logic              acc_en;
    logic [ADC_W-1:0]  scan_val;
    logic [SUM_W-1:0]  trimmed;
    logic [PROD_W:0]   quo_sum;
    logic [PROD_W:0]   rem;
    logic [MV_W-1:0]   mv_value;

    assign pos_cur = pos_reg[cur_ch_reg];
    assign pos_new = (pos_cur == POS_W'(RING_LEN - 1)) ? '0 : pos_cur + 1'b1;

    assign waddr    = ADDR_W'({1'b0, base_reg} + (ADDR_W + 1)'(item_pos_reg));
    assign raddr    = ADDR_W'({1'b0, base_reg} + (ADDR_W + 1)'(idx_reg));
    assign rd_en    = cmd.scan && (idx_reg < IDX_W'(RING_LEN));
    assign acc_en   = cmd.scan && (idx_reg != '0);
    assign scan_val = rvalid_reg ? rdata_reg : '0;

    assign status.scan_done = idx_reg == IDX_W'(RING_LEN);
    assign status.out_free  = !out_valid_reg || out_ready;

    // Channel rotation and per-channel ring positions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_ch_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
            end
        end
        else if (cmd.load)
        begin
            pos_reg[cur_ch_reg] <= pos_new;
            cur_ch_reg <= (cur_ch_reg == CH_W'(CHANNELS - 1)) ? '0 : cur_ch_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg   <= raw_sample;
            item_ch_reg  <= cur_ch_reg;
            item_pos_reg <= pos_new;
            base_reg     <= ADDR_W'(int'(cur_ch_reg) * RING_LEN);
        end
    end

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            ring_mem[waddr] <= sample_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= ring_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    // Ring scan: the read for index k lands while index k+1 is issued.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            idx_reg <= '0;
            sum_reg <= '0;
            lo_reg  <= '1;
            hi_reg  <= '0;
        end
        else if (cmd.scan)
        begin
            if (rd_en)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (acc_en)
            begin
                sum_reg <= sum_reg + SUM_W'(scan_val);
                if (scan_val < lo_reg)
                begin
                    lo_reg <= scan_val;
                end
                if (scan_val > hi_reg)
                begin
                    hi_reg <= scan_val;
                end
            end
        end
    end

    assign trimmed = sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg);

    // Division by 4095 = 2^12 - 1: the estimate (p + p/4096) / 4096 is low
    // by at most one, and one compare against the remainder fixes it.
    assign quo_sum = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(prod_reg >> ADC_W);
    assign rem = (PROD_W + 1)'(prod_reg)
               - (((PROD_W + 1)'(quo_reg) << ADC_W) - (PROD_W + 1)'(quo_reg));
    assign mv_value = (rem >= (PROD_W + 1)'(ADC_MAX)) ? MV_W'(quo_reg + 1'b1)
                                                      : MV_W'(quo_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.trim)
        begin
            avg_reg <= ADC_W'(trimmed >> AVG_SHIFT);
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(avg_reg) * PROD_W'(MV_FULL);
        end
        if (cmd.div)
        begin
            quo_reg <= QUO_W'(quo_sum >> ADC_W);
        end
        if (cmd.emit)
        begin
            channel_reg <= CH_OUT_W'(item_ch_reg);
            average_reg <= avg_reg;
            mv_reg      <= mv_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign channel    = channel_reg;
    assign average    = average_reg;
    assign millivolts = mv_reg;

endmodule

// ----- tb/trimmed_mean_checker.sv -----
// ----------------------------------------------------------------------------
// Trimmed-mean result checker
// Watches the sample and result channels of the averager, keeps its own copy
// of every channel's sample ring, and compares each result word with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module trimmed_mean_checker
    import moa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [ADC_W-1:0]    raw_sample,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [CH_OUT_W-1:0] channel,
    input  logic [ADC_W-1:0]    average,
    input  logic [MV_W-1:0]     millivolts,
    output int                  errors,
    output int                  pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CH_OUT_W-1:0] channel;
        logic [ADC_W-1:0]    average;
        logic [MV_W-1:0]     millivolts;
    } avg_word_t;

    logic [ADC_W-1:0] ring_copy [CHANNELS][RING_LEN];
    int unsigned      slot_copy [CHANNELS];
    int unsigned      chan_copy;
    avg_word_t        awaited_avgs [$];

    // Stores the sample in the current channel's ring and returns the trimmed
    // mean of that ring together with its millivolt value.
    function automatic avg_word_t trimmed_mean_update(input logic [ADC_W-1:0] s);
        avg_word_t   w;
        int unsigned ch;
        int unsigned slot;
        int unsigned sum;
        int unsigned lo;
        int unsigned hi;
        int unsigned avg;
        ch   = chan_copy;
        slot = slot_copy[ch] + 1;
        if (slot >= RING_LEN)
            slot = 0;
        slot_copy[ch]       = slot;
        ring_copy[ch][slot] = s;
        sum = 0;
        lo  = 32'hFFFF_FFFF;
        hi  = 0;
        for (int i = 0; i < RING_LEN; i++)
        begin
            sum += ring_copy[ch][i];
            if (ring_copy[ch][i] < lo)
                lo = ring_copy[ch][i];
            if (ring_copy[ch][i] > hi)
                hi = ring_copy[ch][i];
        end
        avg          = (sum - lo - hi) >> AVG_SHIFT;
        w.channel    = ch[CH_OUT_W-1:0];
        w.average    = avg[ADC_W-1:0];
        w.millivolts = MV_W'((avg * MV_FULL) / ADC_MAX);
        chan_copy    = (ch + 1 >= CHANNELS) ? 0 : ch + 1;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int        bad;
        avg_word_t want;
        if (!rst_n)
        begin
            foreach (ring_copy[c, i])
                ring_copy[c][i] = '0;
            foreach (slot_copy[c])
                slot_copy[c] = 0;
            chan_copy = 0;
            awaited_avgs.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            bad = 0;
            if (in_valid && in_ready)
                awaited_avgs.push_back(trimmed_mean_update(raw_sample));
            if (out_valid && out_ready)
            begin
                if (awaited_avgs.size() == 0)
                begin
                    $error("result word for channel %0d arrived with no sample awaiting it",
                           channel);
                    bad++;
                end
                else
                begin
                    want = awaited_avgs.pop_front();
                    if (channel !== want.channel)
                    begin
                        $error("channel: expected %0d, actual %0d", want.channel, channel);
                        bad++;
                    end
                    if (average !== want.average)
                    begin
                        $error("average: expected %0d, actual %0d", want.average, average);
                        bad++;
                    end
                    if (millivolts !== want.millivolts)
                    begin
                        $error("millivolts: expected %0d, actual %0d",
                               want.millivolts, millivolts);
                        bad++;
                    end
                end
            end
            errors  <= errors + bad;
            pending <= awaited_avgs.size();
        end
    end

endmodule

// ----- tb/multichannel_olympic_average_top_tb.sv -----
// ----------------------------------------------------------------------------
// Multichannel olympic averager testbench
// Feeds directed and random sample words through the round-robin averager
// with random gaps and output stalls, one long output hold-off, and lets the
// checker predict and compare every result word.
// ----------------------------------------------------------------------------
module multichannel_olympic_average_top_tb
    import moa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Sample words to offer at least, directed part included; a last run may exceed it.
    localparam int WORD_COUNT = 1800;

    // Cycles to wait after the last result has been taken.
    localparam int TAIL_CYCLES = 40;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic [ADC_W-1:0]    raw_sample = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [CH_OUT_W-1:0] channel;
    logic [ADC_W-1:0]    average;
    logic [MV_W-1:0]     millivolts;

    int errors;
    int pending;
    int words_sent = 0;

    // Directed opening. The first eight words land on rings that still hold
    // the zeros left by reset, so the trimmed mean is pulled toward zero.
    // Alternating words are among them. Then come single-bit and near-extreme
    // patterns, a run of zeros, and a run of full-scale words that pushes every ring up.
    logic [ADC_W-1:0] directed_words [$] = '{
        12'hFFF, 12'h000, 12'hAAA, 12'h555,
        12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
        12'h001, 12'h800, 12'h7FF, 12'hFFE,
        12'h000, 12'h000, 12'h000, 12'h000,
        12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF,
        12'h002, 12'h400, 12'h020, 12'hF0F
    };

    always #5 clk = ~clk;

    multichannel_olympic_average_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .channel    (channel),
        .average    (average),
        .millivolts (millivolts)
    );

    trimmed_mean_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .raw_sample (raw_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .channel    (channel),
        .average    (average),
        .millivolts (millivolts),
        .errors     (errors),
        .pending    (pending)
    );

    // Offers one sample word and returns at the edge that accepts it. Before
    // the word, the sender idles at random for about a fifth of its cycles,
    // except in a quiet window where words follow back to back. Valid is only
    // lowered when an idle cycle is actually taken, so it never drops and
    // rises within one time step.
    task automatic offer_word(input logic [ADC_W-1:0] s);
        if (words_sent < 600 || words_sent >= 900)
        begin
            while ($urandom_range(99) < 22)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        raw_sample <= s;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // Clamps a noisy value back into the converter's range.
    function automatic logic [ADC_W-1:0] clamp_sample(input int v);
        if (v < 0)
            return '0;
        if (v > ADC_MAX)
            return ADC_W'(ADC_MAX);
        return ADC_W'(v);
    endfunction

    // Result side. The receiver stalls about a fifth of the time, takes every
    // word in a quiet window, and once holds off for a long stretch so the
    // output register stays full and the block has to stop taking samples.
    initial
    begin
        int unsigned cyc;
        int unsigned hold_left;
        cyc       = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc == 3000)
                hold_left = 400;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (cyc >= 12000 && cyc < 18000)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 22);
        end
    end

    // Sample side and verdict.
    initial
    begin
        int          mode;
        int          run;
        int          level;
        int          spread;
        int unsigned pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_words[i])
            offer_word(directed_words[i]);

        // Random part, built from segments. Steady runs are long enough to
        // refill every channel's ring at least once, so the averages settle
        // on the chosen level, full scale and zero among them. Extreme
        // bursts exercise the min and max trimming, and uniform words cover
        // every bit of the sample field.
        while (words_sent < WORD_COUNT)
        begin
            mode = $urandom_range(9);
            if (mode < 5)
            begin
                run  = $urandom_range(60, 40);
                pick = $urandom_range(3);
                if (pick == 0)
                    level = ($urandom_range(1) != 0) ? ADC_MAX : 0;
                else
                    level = $urandom_range(ADC_MAX);
                spread = ($urandom_range(1) != 0) ? 0 : $urandom_range(40);
                repeat (run)
                    offer_word(clamp_sample(level + int'($urandom_range(2 * spread)) - spread));
            end
            else if (mode < 7)
            begin
                run = $urandom_range(40, 10);
                repeat (run)
                    offer_word(($urandom_range(1) != 0) ? ADC_W'(ADC_MAX) : '0);
            end
            else
            begin
                run = $urandom_range(30, 5);
                repeat (run)
                    offer_word(ADC_W'($urandom_range(ADC_MAX)));
            end
        end
        in_valid <= 1'b0;

        // Let the pending count take in the last accepted word before it is polled.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/moa_pkg.sv
sv/moa_ctrl.sv
sv/moa_datapath.sv
sv/multichannel_olympic_average_top.sv
tb/trimmed_mean_checker.sv
tb/multichannel_olympic_average_top_tb.sv
